/* src/tssm_pkg.sv */
// Shared types and constants for the two-stack shared memory unit.
package tssm_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CAP_W   = 9;   // capacity register width
  localparam int COUNT_W = 9;   // stack depth width
  localparam int VALUE_W = 32;  // pop/push word width on the ports
  localparam int CAP_MAX = (1 << CAP_W) - 1;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [1:0] {
    ACT_PUSH_ONE = 2'd0,
    ACT_PUSH_TWO = 2'd1,
    ACT_POP_ONE  = 2'd2,
    ACT_POP_TWO  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // input transaction this cycle
    logic load_out;  // move finished result into the output register
    logic cfg_write; // capacity write, empties both stacks
  } tssm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register empty or being drained
  } tssm_stat_t;

endpackage

/* src/tssm_ctrl.sv */
// Controller state machine: sequences accept and result hand-off.
module tssm_ctrl
  import tssm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  tssm_stat_t stat,
  output tssm_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   rdy_r, rdy_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (rdy_r && in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    rdy_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rdy_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdy_r   <= rdy_nxt;
    end
  end

  assign in_tready     = rdy_r;
  assign cfg_ready     = rdy_r;
  assign cmd.accept    = rdy_r && in_tvalid;
  assign cmd.load_out  = (state_r == S_EXEC) && stat.out_free;
  assign cmd.cfg_write = rdy_r && cfg_valid;

endmodule

/* src/tssm_datapath.sv */
// Datapath: stack counters, shared memory and output register.
module tssm_datapath
  import tssm_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tssm_cmd_t          cmd,
  output tssm_stat_t         stat,
  input  logic [1:0]         action,
  input  logic signed [VALUE_W-1:0] push_value,
  input  logic [CAP_W-1:0]   cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VALUE_W-1:0] out_value,
  output logic [1:0]         out_status,
  output logic [COUNT_W-1:0] out_depth_one,
  output logic [COUNT_W-1:0] out_depth_two
);

  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CAP_LIMIT = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic [COUNT_W-1:0] count_one_r, count_one_nxt;
  logic [COUNT_W-1:0] count_two_r, count_two_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [1:0]         res_status_r;
  logic               res_mem_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [1:0]         out_status_r;
  logic [COUNT_W-1:0] out_d1_r, out_d2_r;

  logic [CAP_W-1:0]   cap_eff;
  logic [COUNT_W:0]   sum;
  logic               room;
  logic [1:0]         status_c;
  logic               mem_we, mem_re;
  logic [CAP_W-1:0]   addr9;

  assign cap_eff = (cap_r > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : cap_r;
  assign sum     = {1'b0, count_one_r} + {1'b0, count_two_r};
  assign room    = sum < {1'b0, cap_eff};

  always_comb begin
    count_one_nxt = count_one_r;
    count_two_nxt = count_two_r;
    cap_nxt       = cap_r;
    status_c      = ST_OK;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    addr9         = count_one_r;
    case (action_t'(action))
      ACT_PUSH_ONE: begin
        addr9 = count_one_r;
        if (room) begin
          mem_we        = cmd.accept;
          count_one_nxt = count_one_r + COUNT_W'(1);
        end else begin
          status_c = ST_OVERFLOW;
        end
      end
      ACT_PUSH_TWO: begin
        addr9 = cap_eff - CAP_W'(1) - count_two_r;
        if (room) begin
          mem_we        = cmd.accept;
          count_two_nxt = count_two_r + COUNT_W'(1);
        end else begin
          status_c = ST_OVERFLOW;
        end
      end
      ACT_POP_ONE: begin
        addr9 = count_one_r - COUNT_W'(1);
        if (count_one_r != '0) begin
          mem_re        = cmd.accept;
          count_one_nxt = count_one_r - COUNT_W'(1);
        end else begin
          status_c = ST_UNDERFLOW;
        end
      end
      default: begin
        // entry at top of stack two, read before the decrement
        addr9 = cap_eff - count_two_r;
        if (count_two_r != '0 && count_two_r <= cap_eff) begin
          mem_re        = cmd.accept;
          count_two_nxt = count_two_r - COUNT_W'(1);
        end else begin
          status_c = ST_UNDERFLOW;
        end
      end
    endcase
    if (!cmd.accept) begin
      count_one_nxt = count_one_r;
      count_two_nxt = count_two_r;
    end
    if (cmd.cfg_write) begin
      cap_nxt       = cfg_data;
      count_one_nxt = '0;
      count_two_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out)             out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_one_r <= '0;
      count_two_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      count_one_r <= count_one_nxt;
      count_two_r <= count_two_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[ADDR_W'(addr9)] <= DATA_WIDTH'($unsigned(push_value));
    if (mem_re) rd_data_r <= mem[ADDR_W'(addr9)];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status_r <= status_c;
      res_mem_r    <= mem_re;
    end
    if (cmd.load_out) begin
      if (res_mem_r) begin
        out_value_r <= VALUE_W'(rd_data_r);
      end else if (res_status_r == ST_UNDERFLOW) begin
        out_value_r <= '1;
      end else begin
        out_value_r <= '0;
      end
      out_status_r <= res_status_r;
      out_d1_r     <= count_one_r;
      out_d2_r     <= count_two_r;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_status    = out_status_r;
  assign out_depth_one = out_d1_r;
  assign out_depth_two = out_d2_r;

endmodule

/* src/two_stacks_shared_memory_unit.sv */
// Top level of the two-stack shared memory unit.
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    tuser: action; tdata: push_value
//   out_     out  out_tvalid/out_tready  tuser: status; tdata: value, depths
//   cfg_     in   cfg_valid/cfg_ready    cfg_data: capacity_in_use
//
// For each item the accept cycle updates the counters and issues the
// memory access; S_EXEC then takes the registered read data into the
// output register once that register is free.
// Reset empties both stacks and sets capacity to 256; memory is not cleared.
// A result waiting in the output register does not block the next accept;
// that item holds in the result stage until the output register frees.
module two_stacks_shared_memory_unit
  import tssm_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,   // [31:0] push_value
  input  logic [1:0]         in_tuser,   // [1:0] action
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [55:0]        out_tdata,  // [31:0] pop_value, [40:32] depth_one,
                                         // [49:41] depth_two, [55:50] zero
  output logic [1:0]         out_tuser,  // [1:0] status
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CAP_W-1:0]   cfg_data    // capacity_in_use
);

  tssm_cmd_t          cmd;
  tssm_stat_t         stat;
  logic [VALUE_W-1:0] pop_value;
  logic [1:0]         status;
  logic [COUNT_W-1:0] depth_one, depth_two;

  tssm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tssm_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .action        (in_tuser),
    .push_value    (in_tdata),
    .cfg_data      (cfg_data),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_value     (pop_value),
    .out_status    (status),
    .out_depth_one (depth_one),
    .out_depth_two (depth_two)
  );

  assign out_tdata = {6'd0, depth_two, depth_one, pop_value};
  assign out_tuser = status;

`ifndef NO_ASSERTIONS
  // one item at a time: an accept drops ready for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

  a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OVERFLOW |-> out_tdata[31:0] == 32'd0)
    else $error("refused push returned nonzero value");

  a_underflow_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_UNDERFLOW |-> out_tdata[31:0] == 32'hFFFF_FFFF)
    else $error("underflow did not return all ones");

  a_depth_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[40:32]} + {1'b0, out_tdata[49:41]}) <= 10'd511)
    else $error("combined stack depth out of range");
`endif

endmodule

/* dv/tb.sv */
// Testbench for the two-stack shared memory unit: random stack traffic checked by a scoreboard.
module tb;
  import tssm_pkg::*;

  localparam int MEM_ENTRIES = DEPTH_DEF;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TOTAL_ITEMS = 1900;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic [COUNT_W-1:0] depth_one;
    logic [COUNT_W-1:0] depth_two;
  } stack_result_t;

  class stack_scoreboard;
    logic [VALUE_W-1:0] words [MEM_ENTRIES];
    int unsigned cap_reg;
    int unsigned depth1;
    int unsigned depth2;
    stack_result_t expected_q [$];
    int unsigned mismatches;

    function new();
      cap_reg = CAP_RESET;
      depth1 = 0;
      depth2 = 0;
      mismatches = 0;
    endfunction

    // a capacity write also empties both stacks; memory is kept
    function void set_capacity(logic [CAP_W-1:0] v);
      cap_reg = v;
      depth1 = 0;
      depth2 = 0;
    endfunction

    function void note_input(action_t act, logic [VALUE_W-1:0] word);
      int unsigned cap;
      stack_result_t r;
      cap = (cap_reg > MEM_ENTRIES) ? MEM_ENTRIES : cap_reg;
      r.value = '0;
      r.status = ST_OK;
      case (act)
        ACT_PUSH_ONE: begin
          if (depth1 + depth2 < cap) begin
            words[depth1] = word;
            depth1++;
          end else r.status = ST_OVERFLOW;
        end
        ACT_PUSH_TWO: begin
          if (depth1 + depth2 < cap) begin
            words[cap - 1 - depth2] = word;
            depth2++;
          end else r.status = ST_OVERFLOW;
        end
        ACT_POP_ONE: begin
          if (depth1 > 0) begin
            depth1--;
            r.value = words[depth1];
          end else begin
            r.value = '1;
            r.status = ST_UNDERFLOW;
          end
        end
        default: begin
          if (depth2 > 0) begin
            depth2--;
            r.value = words[cap - 1 - depth2];
          end else begin
            r.value = '1;
            r.status = ST_UNDERFLOW;
          end
        end
      endcase
      r.depth_one = depth1[COUNT_W-1:0];
      r.depth_two = depth2[COUNT_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(stack_result_t got);
      stack_result_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h status %s depths %0d/%0d",
                   got.value, got.status.name(), got.depth_one, got.depth_two);
        return;
      end
      exp = expected_q.pop_front();
      if (got.value !== exp.value || got.status !== exp.status ||
          got.depth_one !== exp.depth_one || got.depth_two !== exp.depth_two) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: exp value %h status %s depths %0d/%0d",
                   $time, exp.value, exp.status.name(), exp.depth_one, exp.depth_two);
          $display("  got value %h status %s depths %0d/%0d",
                   got.value, got.status.name(), got.depth_one, got.depth_two);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [31:0]        in_tdata = '0;   // [31:0] push_value
  logic [1:0]         in_tuser = '0;   // [1:0] action
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [55:0]        out_tdata;       // [31:0] pop_value, [40:32] depth_one,
                                       // [49:41] depth_two, [55:50] zero
  logic [1:0]         out_tuser;       // [1:0] status
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CAP_W-1:0]   cfg_data = '0;

  stack_scoreboard sb = new();
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;

  two_stacks_shared_memory_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(action_t act, logic [31:0] word);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
    sb.note_input(act, word);
    items_sent++;
  endtask

  task automatic idle_in(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  // waits for the block to drain before the capacity write
  task automatic write_capacity(logic [CAP_W-1:0] v);
    idle_in(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_capacity(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data <= CAP_W'($urandom());
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 19))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 9))
      0: return CAP_W'(1);
      1: return CAP_W'(2);
      2: return CAP_W'(3);
      3: return CAP_W'($urandom_range(4, 16));
      4: return CAP_RESET;
      5: return CAP_W'(CAP_MAX);
      6: return '0;
      7: return CAP_W'($urandom_range(257, CAP_MAX - 1));
      8: return CAP_W'($urandom_range(17, 255));
      default: return CAP_W'($urandom_range(1, CAP_MAX));
    endcase
  endfunction

  task automatic random_phase(logic [CAP_W-1:0] cap);
    int unsigned eff;
    int unsigned count;
    int unsigned run_len;
    bit push_heavy;
    bit quiet;
    bit do_push;
    action_t act;
    eff = (cap > MEM_ENTRIES) ? MEM_ENTRIES : cap;
    count = (eff >= 64) ? 320 : 110;
    while (count > 0 && items_sent < TOTAL_ITEMS) begin
      // bursts biased to pushes or pops so both full and empty stacks are reached
      push_heavy = ~push_heavy;
      quiet = ($urandom_range(0, 3) == 0);
      run_len = $urandom_range(1, eff + 4);
      while (run_len > 0 && count > 0 && items_sent < TOTAL_ITEMS) begin
        do_push = ($urandom_range(0, 99) < 85) ? push_heavy : !push_heavy;
        if (do_push) act = $urandom_range(0, 1) ? ACT_PUSH_TWO : ACT_PUSH_ONE;
        else act = $urandom_range(0, 1) ? ACT_POP_TWO : ACT_POP_ONE;
        send_item(act, pick_word());
        idle_in(pick_gap(quiet));
        run_len--;
        count--;
      end
    end
  endtask

  // receiver: random stalls with quiet stretches
  initial begin
    int unsigned hold;
    int unsigned stretch;
    bit quiet;
    hold = 0;
    stretch = 0;
    quiet = 1'b0;
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        stretch = $urandom_range(50, 200);
      end
      stretch--;
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
        hold = pick_gap(quiet);
      end
    end
  end

  always @(posedge clk) begin
    stack_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.value = out_tdata[31:0];
      got.depth_one = out_tdata[40:32];
      got.depth_two = out_tdata[49:41];
      got.status = status_t'(out_tuser);
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset capacity: underflow on both, extremes, then drain
    send_item(ACT_POP_ONE, 32'h1234_5678);
    send_item(ACT_POP_TWO, 32'h8765_4321);
    send_item(ACT_PUSH_ONE, 32'h7FFF_FFFF);
    send_item(ACT_PUSH_TWO, 32'h8000_0000);
    send_item(ACT_PUSH_ONE, 32'h0000_0000);
    send_item(ACT_PUSH_TWO, 32'hFFFF_FFFF);
    send_item(ACT_POP_ONE, 32'h0);
    send_item(ACT_POP_ONE, 32'h0);
    send_item(ACT_POP_TWO, 32'h0);
    send_item(ACT_POP_TWO, 32'h0);

    // smallest nonzero capacity: one push fills it
    write_capacity(CAP_W'(1));
    send_item(ACT_PUSH_TWO, 32'hA5A5_A5A5);
    send_item(ACT_PUSH_ONE, 32'h0000_0001);
    send_item(ACT_PUSH_TWO, 32'hFFFF_FFFE);
    send_item(ACT_POP_ONE, 32'h0);
    send_item(ACT_POP_TWO, 32'h0);
    send_item(ACT_PUSH_ONE, 32'h5A5A_5A5A);
    send_item(ACT_POP_ONE, 32'h0);

    // zero capacity: every push overflows
    write_capacity('0);
    send_item(ACT_PUSH_ONE, 32'h1111_1111);
    send_item(ACT_PUSH_TWO, 32'h2222_2222);
    send_item(ACT_POP_TWO, 32'h0);

    // capacity above memory size saturates; stack two uses the top entry
    write_capacity(CAP_W'(CAP_MAX));
    send_item(ACT_PUSH_TWO, 32'hDEAD_BEEF);
    send_item(ACT_POP_TWO, 32'h0);

    write_capacity(CAP_W'(2));
    send_item(ACT_PUSH_ONE, 32'h0F0F_0F0F);
    send_item(ACT_PUSH_TWO, 32'hF0F0_F0F0);
    send_item(ACT_PUSH_ONE, 32'h3333_3333);

    while (items_sent < TOTAL_ITEMS) begin
      logic [CAP_W-1:0] cap;
      cap = pick_capacity();
      write_capacity(cap);
      random_phase(cap);
    end

    idle_in(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
